[rtl/ghcb_pkg.sv]
// shared types, constants and gear table for the gear hash chunker
package ghcb_pkg;

    // default width of the byte position and chunk start counters
    localparam int POS_BITS_DEFAULT = 48;

    // fixed field widths
    localparam int LEN_W  = 32;
    localparam int FPOS_W = 48;
    localparam int HASH_W = 64;

    // register reset values
    localparam logic [LEN_W-1:0]  RST_MIN_CHUNK   = 32'd524288;
    localparam logic [LEN_W-1:0]  RST_AVG_CHUNK   = 32'd2097152;
    localparam logic [LEN_W-1:0]  RST_MAX_CHUNK   = 32'd8388608;
    localparam logic [FPOS_W-1:0] RST_FILE_LENGTH = 48'd0;

    // splitmix64 constants
    localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX1   = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX2   = 64'h94D049BB133111EB;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_MIN_CHUNK   = 2'd0,
        CFG_AVG_CHUNK   = 2'd1,
        CFG_MAX_CHUNK   = 2'd2,
        CFG_FILE_LENGTH = 2'd3
    } cfg_index_t;

    // configuration plus values derived from it, held in registers
    typedef struct packed {
        logic [LEN_W-1:0]  min_size;
        logic [LEN_W-1:0]  max_size;
        logic [FPOS_W-1:0] file_length;
        logic [LEN_W-1:0]  mask;
        logic [FPOS_W-1:0] last_valid;
        logic              tail_all;
        logic [LEN_W-1:0]  tail_thr;
    } cfg_t;

    // registered input word: gear value already looked up
    typedef struct packed {
        logic [HASH_W-1:0] gear;
        logic              first;
    } byte_word_t;

    // mask = largest power of two not above avg, minus one
    function automatic logic [LEN_W-1:0] cut_mask_of(input logic [LEN_W-1:0] avg);
        logic [LEN_W-1:0] s;
        s = avg;
        s = s | (s >> 1);
        s = s | (s >> 2);
        s = s | (s >> 4);
        s = s | (s >> 8);
        s = s | (s >> 16);
        return s >> 1;
    endfunction

    // last legal cut position
    function automatic logic [FPOS_W-1:0] last_valid_of(input logic [FPOS_W-1:0] flen,
                                                        input logic [LEN_W-1:0] mn);
        logic [FPOS_W-1:0] mn_ext;
        mn_ext = FPOS_W'(mn);
        return (flen > mn_ext) ? (flen - mn_ext) : '0;
    endfunction

    // splitmix64 of (b + 2) * golden
    function automatic logic [63:0] gear_of(input logic [7:0] b);
        logic [63:0] z;
        z = (64'(b) + 64'd2) * GOLDEN;
        z = (z ^ (z >> 30)) * MIX1;
        z = (z ^ (z >> 27)) * MIX2;
        return z ^ (z >> 31);
    endfunction

    typedef logic [HASH_W-1:0] gear_rom_t [0:255];

    function automatic gear_rom_t gear_rom_build();
        gear_rom_t rom;
        for (int i = 0; i < 256; i++)
        begin
            rom[i] = gear_of(8'(i));
        end
        return rom;
    endfunction

    // gear table, fixed at elaboration
    localparam gear_rom_t GEAR_ROM = gear_rom_build();

    // reset values of derived registers
    localparam logic [LEN_W-1:0]  RST_MASK       = cut_mask_of(RST_AVG_CHUNK);
    localparam logic [FPOS_W-1:0] RST_LAST_VALID = last_valid_of(RST_FILE_LENGTH,
                                                                 RST_MIN_CHUNK);
    localparam logic              RST_TAIL_ALL   = (RST_MAX_CHUNK < RST_MIN_CHUNK);
    localparam logic [LEN_W-1:0]  RST_TAIL_THR   = RST_MAX_CHUNK - RST_MIN_CHUNK;

endpackage

[rtl/ghcb_config.sv]
// configuration registers and values derived from them
module ghcb_config
    import ghcb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [FPOS_W-1:0] cfg_data,
    output cfg_t              cfg
);

    logic [LEN_W-1:0]  min_size_reg, min_size_next;
    logic [LEN_W-1:0]  avg_chunk_reg, avg_chunk_next;
    logic [LEN_W-1:0]  max_size_reg, max_size_next;
    logic [FPOS_W-1:0] file_length_reg, file_length_next;
    logic [LEN_W-1:0]  mask_reg;
    logic [FPOS_W-1:0] last_valid_reg;
    logic              tail_all_reg;
    logic [LEN_W-1:0]  tail_thr_reg;

    // register write decode
    always_comb
    begin
        min_size_next    = min_size_reg;
        avg_chunk_next   = avg_chunk_reg;
        max_size_next    = max_size_reg;
        file_length_next = file_length_reg;
        if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MIN_CHUNK:   min_size_next    = cfg_data[LEN_W-1:0];
                CFG_AVG_CHUNK:   avg_chunk_next   = cfg_data[LEN_W-1:0];
                CFG_MAX_CHUNK:   max_size_next    = cfg_data[LEN_W-1:0];
                CFG_FILE_LENGTH: file_length_next = cfg_data;
                default:         ;
            endcase
        end
    end

    // user registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_size_reg    <= RST_MIN_CHUNK;
            avg_chunk_reg   <= RST_AVG_CHUNK;
            max_size_reg    <= RST_MAX_CHUNK;
            file_length_reg <= RST_FILE_LENGTH;
        end
        else
        begin
            min_size_reg    <= min_size_next;
            avg_chunk_reg   <= avg_chunk_next;
            max_size_reg    <= max_size_next;
            file_length_reg <= file_length_next;
        end
    end

    // derived values are registered from the user registers, in the cycle after them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg       <= RST_MASK;
            last_valid_reg <= RST_LAST_VALID;
            tail_all_reg   <= RST_TAIL_ALL;
            tail_thr_reg   <= RST_TAIL_THR;
        end
        else
        begin
            mask_reg       <= cut_mask_of(avg_chunk_reg);
            last_valid_reg <= last_valid_of(file_length_reg, min_size_reg);
            tail_all_reg   <= (max_size_reg < min_size_reg);
            tail_thr_reg   <= max_size_reg - min_size_reg;
        end
    end

    assign cfg.min_size    = min_size_reg;
    assign cfg.max_size    = max_size_reg;
    assign cfg.file_length = file_length_reg;
    assign cfg.mask        = mask_reg;
    assign cfg.last_valid  = last_valid_reg;
    assign cfg.tail_all    = tail_all_reg;
    assign cfg.tail_thr    = tail_thr_reg;

    // mask is always a run of low ones
    a_mask_low_ones: assert property (@(posedge clk) disable iff (!rst_n)
        (mask_reg & (mask_reg + 32'd1)) == '0)
        else $error("cut mask is not a run of low ones");

    // last legal cut position never lies past the file end
    a_last_valid_in_file: assert property (@(posedge clk) disable iff (!rst_n)
        last_valid_reg <= $past(file_length_reg))
        else $error("last legal cut position beyond file length");

endmodule

[rtl/ghcb_input_stage.sv]
// input register with gear table lookup
module ghcb_input_stage
    import ghcb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       first_of_file,
    input  logic       advance,
    output logic       word_valid,
    output byte_word_t word
);

    logic       valid_reg, valid_next;
    byte_word_t word_reg;
    logic       load;

    // the stage takes a word when empty or when its word moves on
    assign in_ready = !valid_reg || advance;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // gear lookup on the way in
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg.gear  <= GEAR_ROM[data_byte];
            word_reg.first <= first_of_file;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

    // a held word stays put while the core stalls
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !advance |=> valid_reg && $stable(word_reg))
        else $error("input word changed while stalled");

endmodule

[rtl/ghcb_core.sv]
// rolling hash, position tracking, cut decision and result register
module ghcb_core
    import ghcb_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              word_valid,
    input  byte_word_t        word,
    output logic              advance,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [FPOS_W-1:0] cut_position,
    output logic [LEN_W-1:0]  chunk_length
);

    // compare width covers both the position and the 48-bit file length
    localparam int CW = (POS_BITS > FPOS_W) ? POS_BITS : FPOS_W;

    logic [HASH_W-1:0]   hash_reg, hash_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] start_reg, start_next;
    logic                out_valid_reg, out_valid_next;
    logic [FPOS_W-1:0]   cut_position_reg;
    logic [LEN_W-1:0]    chunk_length_reg;

    logic                fire;
    logic [HASH_W-1:0]   hash_base, hash_new;
    logic [POS_BITS-1:0] pos_base, pos_new, start_base, size;
    logic [CW-1:0]       pos_ext, size_ext, flen_ext, min_ext, max_ext;
    logic                match, boundary, overflow, tail_cut, enough_left, cut;
    logic [LEN_W-1:0]    len_sat;

    // the result slot is free or being emptied
    assign advance = !out_valid_reg || out_ready;
    assign fire    = word_valid && advance;

    // hash and position update, restarted on the first byte of a file
    always_comb
    begin
        hash_base  = word.first ? '0 : hash_reg;
        pos_base   = word.first ? '0 : pos_reg;
        start_base = word.first ? '0 : start_reg;
        hash_new   = {hash_base[HASH_W-2:0], 1'b0} + word.gear;
        pos_new    = pos_base + POS_BITS'(1);
        size       = pos_new - start_base;
    end

    // cut conditions
    always_comb
    begin
        pos_ext     = CW'(pos_new);
        size_ext    = CW'(size);
        flen_ext    = CW'(cfg.file_length);
        min_ext     = CW'(cfg.min_size);
        max_ext     = CW'(cfg.max_size);
        match       = (hash_new[LEN_W-1:0] & cfg.mask) == '0;
        boundary    = match && (size_ext >= min_ext) && (size_ext < max_ext);
        overflow    = size_ext >= max_ext;
        tail_cut    = (pos_ext == CW'(cfg.last_valid)) && (size_ext >= min_ext)
                      && (cfg.tail_all || (size_ext > CW'(cfg.tail_thr)));
        enough_left = (pos_ext < flen_ext) && ((flen_ext - pos_ext) >= min_ext);
        cut         = (boundary || overflow || tail_cut) && enough_left;
        len_sat     = (|size_ext[CW-1:LEN_W]) ? '1 : size_ext[LEN_W-1:0];
    end

    // next state
    always_comb
    begin
        hash_next      = hash_reg;
        pos_next       = pos_reg;
        start_next     = start_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = fire && cut;
        end
        if (fire)
        begin
            hash_next  = cut ? '0 : hash_new;
            pos_next   = pos_new;
            start_next = cut ? pos_new : start_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= '0;
            pos_reg       <= '0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hash_reg      <= hash_next;
            pos_reg       <= pos_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire && cut)
        begin
            cut_position_reg <= pos_ext[FPOS_W-1:0];
            chunk_length_reg <= len_sat;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cut_position = cut_position_reg;
    assign chunk_length = chunk_length_reg;

    // a cut clears the hash
    a_cut_clears_hash: assert property (@(posedge clk) disable iff (!rst_n)
        fire && cut |=> hash_reg == '0)
        else $error("hash not cleared after cut");

    // a reported cut matches the new chunk start
    a_cut_is_start: assert property (@(posedge clk) disable iff (!rst_n)
        fire && cut |=> start_reg == pos_reg
                        && cut_position_reg == FPOS_W'(CW'(pos_reg)))
        else $error("cut position disagrees with chunk start");

    // a new word only shows up after a processed byte
    a_out_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fire))
        else $error("result appeared without a processed byte");

endmodule

[rtl/gear_hash_chunk_boundary.sv]
// Gear hash content-defined chunker. Bytes of a file enter one word per cycle on
// in_valid/in_ready unless a held result waits on out_ready; each byte passes an
// input register (where its gear value is looked up in a fixed 256-entry table),
// is folded into a 64-bit rolling hash with the cut decision made in the same
// cycle, and the cut is written to an output register. Throughput is one byte per
// cycle under that condition; the hash/position feedback loop (one 64-bit add plus
// the mask and size compares) sets the clock. A result word carries the offset
// where the new chunk begins and the closed chunk's length; bytes that do not cut
// give no word. Set first_of_file on the first byte of each file. Configuration
// writes take effect for bytes accepted from the cycle after the write on and
// should be made while no bytes are in flight.
module gear_hash_chunk_boundary
    import ghcb_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [FPOS_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        data_byte,
    input  logic              first_of_file,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [FPOS_W-1:0] cut_position,
    output logic [LEN_W-1:0]  chunk_length
);

    cfg_t       cfg;
    logic       advance;
    logic       word_valid;
    byte_word_t word;

    // configuration registers
    ghcb_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register and gear lookup
    ghcb_input_stage u_input (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .first_of_file (first_of_file),
        .advance       (advance),
        .word_valid    (word_valid),
        .word          (word)
    );

    // hash, cut decision and result register
    ghcb_core #(
        .POS_BITS (POS_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .word_valid   (word_valid),
        .word         (word),
        .advance      (advance),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cut_position (cut_position),
        .chunk_length (chunk_length)
    );

endmodule
